### hdl/bpcs_pkg.sv
package bpcs_pkg;

  // Default image geometry.
  localparam int DEF_IMAGE_COLUMNS = 120;
  localparam int DEF_IMAGE_PAGES   = 4;
  localparam int DEF_ROW_BYTES     = 15;

  // Pixel rows in one display page.
  localparam int PAGE_ROWS = 8;

  // Function codes of an input beat.
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_RENDER = 1'b1;

  // One input beat.
  typedef struct packed {
    logic               func;
    logic [8:0]         load_index;
    logic [7:0]         load_byte;
    logic [1:0]         page;
    logic [6:0]         column;
    logic signed [7:0]  scroll;
  } in_item_t;

  // One result beat.
  typedef struct packed {
    logic [7:0] column_byte;
    logic       in_window;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic ram_we;
    logic clear_acc;
    logic rd_en;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic func;
    logic in_image;
  } dp_sts_t;

endpackage

### hdl/bpcs_ram.sv
module bpcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 480
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port, registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### hdl/bpcs_ctrl.sv
module bpcs_ctrl
  import bpcs_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  dp_sts_t sts,
  output logic    busy,
  output logic    out_valid,
  output dp_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WRITE = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = S_WRITE;
        end
      end
      S_WRITE: begin
        // The captured beat decides whether this is a store write or a render.
        if (sts.func == FUNC_LOAD) begin
          cmd.ram_we = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          cmd.clear_acc = 1'b1;
          state_nxt     = S_CHECK;
        end
      end
      S_CHECK: begin
        cnt_nxt   = '0;
        state_nxt = sts.in_image ? S_READ : S_OUT;
      end
      S_READ: begin
        // One pixel row read per cycle.
        cmd.rd_en = 1'b1;
        cnt_nxt   = cnt_r + 3'd1;
        if (cnt_r == 3'(PAGE_ROWS - 1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // A result beat never coincides with an accept.
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result strobe while idle");

  // An accepted beat makes the block busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accept did not raise busy");

  // Each render gives a single result strobe.
  a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe repeated");

  // The store port is never written during a row read.
  a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ram_we |-> !cmd.rd_en) else $error("store port conflict");

endmodule

### hdl/bpcs_dp.sv
module bpcs_dp
  import bpcs_pkg::*;
#(
  parameter int IMAGE_COLUMNS = DEF_IMAGE_COLUMNS,
  parameter int IMAGE_PAGES   = DEF_IMAGE_PAGES,
  parameter int ROW_BYTES     = DEF_ROW_BYTES
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  dp_cmd_t   cmd,
  output dp_sts_t   sts,
  output out_item_t out_data
);

  localparam int DEPTH = IMAGE_PAGES * PAGE_ROWS * ROW_BYTES;
  localparam int AW    = $clog2(DEPTH);

  logic          func_r;
  logic          load_ok_r;
  logic [7:0]    load_byte_r;
  logic [AW-1:0] load_addr_r;
  logic          inside_r;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [2:0]    bit_idx_r;
  logic [7:0]    acc_r, acc_nxt;
  logic          rd_v_r;

  logic signed [8:0] shifted;
  logic [4:0]        byte_sel;
  logic              in_image;
  logic [11:0]       base_wide;
  logic              load_ok;
  logic [AW-1:0]     ram_addr;
  logic [7:0]        ram_rdata;

  // Shifted column, window test and first row address of the page.
  always_comb begin
    shifted   = $signed({2'b00, in_data.column}) + 9'(in_data.scroll);
    byte_sel  = shifted[7:3];
    in_image  = (4'({2'b00, in_data.page}) < 4'(IMAGE_PAGES)) && !shifted[8] &&
                (shifted[7:0] < 8'(IMAGE_COLUMNS)) && (byte_sel < 5'(ROW_BYTES));
    base_wide = 12'(in_data.page) * 12'(PAGE_ROWS * ROW_BYTES) + 12'(byte_sel);
    load_ok   = (11'(in_data.load_index) < 11'(DEPTH));
  end

  // Beat capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r      <= in_data.func;
      load_ok_r   <= load_ok;
      load_byte_r <= in_data.load_byte;
      load_addr_r <= AW'(in_data.load_index);
      inside_r    <= in_image;
      bit_idx_r   <= ~shifted[2:0];
    end
    addr_r <= addr_nxt;
    acc_r  <= acc_nxt;
  end

  // Row address walks down the page one row at a time.
  always_comb begin
    addr_nxt = addr_r;
    if (cmd.capture) begin
      addr_nxt = AW'(base_wide);
    end else if (cmd.rd_en) begin
      addr_nxt = addr_r + AW'(ROW_BYTES);
    end
  end

  // Read data arrives in the cycle after the read; rows shift in from the top.
  always_comb begin
    acc_nxt = acc_r;
    if (cmd.clear_acc) begin
      acc_nxt = '0;
    end else if (rd_v_r) begin
      acc_nxt = {ram_rdata[bit_idx_r], acc_r[7:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
    end else begin
      rd_v_r <= cmd.rd_en;
    end
  end

  assign ram_addr = cmd.ram_we ? load_addr_r : addr_r;

  bpcs_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (cmd.ram_we && load_ok_r),
    .addr (ram_addr),
    .wdata(load_byte_r),
    .rdata(ram_rdata)
  );

  assign sts.func              = func_r;
  assign sts.in_image          = inside_r;
  assign out_data.column_byte  = acc_r;
  assign out_data.in_window    = inside_r;

endmodule

### hdl/bitmap_to_page_column_scroller_core.sv
// Load beat: busy only in the write state after the accept, then idle for the next accept.
// Render inside the image: after the accept the controller steps through write, check,
// one store read per pixel row (eight reads on the single store port), drain, then the
// result strobe. Render outside the image: write and check, then the strobe, no store reads.
// Synchronous active-low reset returns the controller to idle; the image store is not cleared.
// The receiver cannot stall: each result is marked by out_valid for exactly one cycle.
module bitmap_to_page_column_scroller_core
  import bpcs_pkg::*;
#(
  parameter int IMAGE_COLUMNS = DEF_IMAGE_COLUMNS,
  parameter int IMAGE_PAGES   = DEF_IMAGE_PAGES,
  parameter int ROW_BYTES     = DEF_ROW_BYTES
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_valid,
  output out_item_t out_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer.
  bpcs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .sts      (sts),
    .busy     (busy),
    .out_valid(out_valid),
    .cmd      (cmd)
  );

  // Image store and column gather.
  bpcs_dp #(
    .IMAGE_COLUMNS(IMAGE_COLUMNS),
    .IMAGE_PAGES  (IMAGE_PAGES),
    .ROW_BYTES    (ROW_BYTES)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_data),
    .cmd     (cmd),
    .sts     (sts),
    .out_data(out_data)
  );

endmodule

### bench/bitmap_to_page_column_scroller_core_test.sv
module bitmap_to_page_column_scroller_core_test;
  import bpcs_pkg::*;

  localparam int COLS         = DEF_IMAGE_COLUMNS;
  localparam int PAGES        = DEF_IMAGE_PAGES;
  localparam int ROWB         = DEF_ROW_BYTES;
  localparam int STORE_BYTES  = PAGES * PAGE_ROWS * ROWB;
  localparam int RANDOM_BEATS = 500;
  localparam int SETTLE_TICKS = 16;
  localparam int TIMEOUT_UNITS = 4000000;

  // One pending input beat with the idle gap that follows it.
  typedef struct {
    in_item_t beat;
    int       gap;
    bit       hold;
  } beat_slot_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_data = '0;
  logic      out_valid;
  out_item_t out_data;

  beat_slot_t pending_beats[$];
  out_item_t  expected_columns[$];
  logic [7:0] shadow_image [STORE_BYTES];
  bit         pixel_written [STORE_BYTES];
  bit         quiet_run = 1'b0;
  bit         hold_next = 1'b0;
  bit         beat_taken = 1'b0;
  int         gap_left = 0;
  int         mismatch_count = 0;

  bitmap_to_page_column_scroller_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Synchronous reset held low from the start, released at a falling edge.
  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #TIMEOUT_UNITS;
    $display("Regression FAIL");
    $finish;
  end

  // Mostly short gaps, a few long ones, none at all during a quiet run.
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (quiet_run || p < 45) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic in_item_t random_beat();
    in_item_t b;
    b.func       = 1'($urandom_range(0, 1));
    b.load_index = 9'($urandom_range(0, 511));
    b.load_byte  = 8'($urandom_range(0, 255));
    b.page       = 2'($urandom_range(0, 3));
    b.column     = 7'($urandom_range(0, 127));
    b.scroll     = 8'($urandom_range(0, 255));
    return b;
  endfunction

  task automatic queue_beat(input in_item_t b);
    beat_slot_t s;
    s.beat = b;
    s.gap  = pick_gap();
    s.hold = hold_next;
    hold_next = 1'b0;
    pending_beats.push_back(s);
    if (b.func == FUNC_LOAD && int'(b.load_index) < STORE_BYTES)
      pixel_written[b.load_index] = 1'b1;
  endtask

  task automatic load_pixels(input int idx, input logic [7:0] value);
    in_item_t b;
    b = random_beat();
    b.func       = FUNC_LOAD;
    b.load_index = 9'(idx);
    b.load_byte  = value;
    queue_beat(b);
  endtask

  // A render whose column lands in the image first loads any byte it would
  // read that has never been written.
  task automatic render_column(input int pg, input int col, input int shift);
    in_item_t b;
    int       shifted;
    int       addr;
    shifted = col + shift;
    if (pg < PAGES && shifted >= 0 && shifted < COLS) begin
      for (int r = 0; r < PAGE_ROWS; r++) begin
        addr = (pg * PAGE_ROWS + r) * ROWB + (shifted >> 3);
        if (!pixel_written[addr]) load_pixels(addr, 8'($urandom_range(0, 255)));
      end
    end
    b = random_beat();
    b.func   = FUNC_RENDER;
    b.page   = 2'(pg);
    b.column = 7'(col);
    b.scroll = 8'(shift);
    queue_beat(b);
  endtask

  // Predict the result of one accepted beat; loads update the image copy.
  function automatic bit predict_column(input in_item_t b, output out_item_t r);
    int shifted;
    int addr;
    logic [7:0] pix;
    r = '0;
    if (b.func == FUNC_LOAD) begin
      if (int'(b.load_index) < STORE_BYTES) shadow_image[b.load_index] = b.load_byte;
      return 1'b0;
    end
    shifted = int'(b.column) + int'($signed(b.scroll));
    if (int'(b.page) < PAGES && shifted >= 0 && shifted < COLS && (shifted >> 3) < ROWB) begin
      r.in_window = 1'b1;
      for (int row = 0; row < PAGE_ROWS; row++) begin
        addr = (int'(b.page) * PAGE_ROWS + row) * ROWB + (shifted >> 3);
        pix  = shadow_image[addr];
        r.column_byte[row] = pix[7 - (shifted & 7)];
      end
    end
    return 1'b1;
  endfunction

  task automatic note_mismatch(input string what, input int want, input int got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch at %0t: %s expected %0h got %0h", $realtime, what, want, got);
  endtask

  // Driver: moves one beat per handshake, honoring gaps and drain requests.
  always @(negedge clk) begin : drive
    logic     next_start;
    in_item_t next_data;
    next_start = 1'b0;
    next_data  = in_data;
    if (!rst_n) begin
      next_start = 1'b0;
    end else if (start && !beat_taken) begin
      next_start = 1'b1;
    end else if (gap_left > 0) begin
      gap_left--;
    end else if (pending_beats.size() != 0 &&
                 !(pending_beats[0].hold && expected_columns.size() != 0)) begin
      next_data  = pending_beats[0].beat;
      gap_left   = pending_beats[0].gap;
      next_start = 1'b1;
      pending_beats.pop_front();
    end
    start   <= next_start;
    in_data <= next_data;
  end

  // Monitor: checks result beats, then predicts for the beat accepted now.
  always @(posedge clk) begin : watch
    out_item_t want;
    out_item_t fresh;
    beat_taken <= rst_n && start && !busy;
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        if (expected_columns.size() == 0) begin
          note_mismatch("unexpected result beat", 0, int'(out_data));
        end else begin
          want = expected_columns.pop_front();
          if (out_data.column_byte !== want.column_byte)
            note_mismatch("column_byte", int'(want.column_byte),
                          int'(out_data.column_byte));
          if (out_data.in_window !== want.in_window)
            note_mismatch("in_window", int'(want.in_window), int'(out_data.in_window));
        end
      end
      if (start && !busy && predict_column(in_data, fresh))
        expected_columns.push_back(fresh);
    end
  end

  // Stimulus, then wait for the block to finish and report.
  initial begin
    int counted;
    int p;
    int idx;
    int shift;

    // Directed: store corners, ignored addresses, window edges and scroll extremes.
    load_pixels(0, 8'hFF);
    load_pixels(STORE_BYTES - 1, 8'h01);
    load_pixels(STORE_BYTES, 8'hFF);
    load_pixels(511, 8'hAA);
    render_column(0, 0, 0);
    render_column(0, 7, 0);
    render_column(3, 119, 0);
    render_column(3, 127, -8);
    render_column(3, 100, 19);
    render_column(3, 100, 20);
    render_column(1, 120, 0);
    render_column(2, 0, -1);
    render_column(0, 127, -128);
    render_column(2, 0, 127);
    render_column(3, 127, 127);

    // Random: loads and renders, mostly landing in the image. The total counts
    // every queued beat, including the loads that a render adds first.
    hold_next = 1'b1;
    counted = 0;
    while (pending_beats.size() < RANDOM_BEATS) begin
      if (counted % 50 == 0) quiet_run = ($urandom_range(0, 2) == 0);
      if (counted == RANDOM_BEATS / 5) hold_next = 1'b1;
      p = $urandom_range(0, 99);
      if (p < 3) begin
        load_pixels($urandom_range(STORE_BYTES, 511), 8'($urandom_range(0, 255)));
      end else if (p < 38) begin
        idx = $urandom_range(0, STORE_BYTES - 1);
        load_pixels(idx, 8'($urandom_range(0, 255)));
      end else begin
        if ($urandom_range(0, 3) == 0) shift = $urandom_range(0, 255) - 128;
        else shift = $urandom_range(0, 40) - 20;
        render_column($urandom_range(0, 3), $urandom_range(0, 127), shift);
      end
      counted++;
    end

    do @(posedge clk);
    while (pending_beats.size() != 0 || start || expected_columns.size() != 0);
    repeat (SETTLE_TICKS) @(posedge clk);
    if (expected_columns.size() != 0)
      note_mismatch("results never delivered", expected_columns.size(), 0);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### sim.f
hdl/bpcs_pkg.sv
hdl/bpcs_ram.sv
hdl/bpcs_ctrl.sv
hdl/bpcs_dp.sv
hdl/bitmap_to_page_column_scroller_core.sv
bench/bitmap_to_page_column_scroller_core_test.sv
